/* rtl/ria_pkg.sv */
// Shared types and codes for the reference-counted ID allocator.
`default_nettype none

package ria_pkg;

  typedef enum logic [2:0] {
    FUNC_ADD  = 3'd0,
    FUNC_DEL  = 3'd1,
    FUNC_GEN  = 3'd2,
    FUNC_CLR  = 3'd3,
    FUNC_READ = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_RANGE     = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_ABSENT    = 3'd3,
    STAT_NONE_FREE = 3'd4,
    STAT_BAD_POS   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHIFT_UP,
    S_INSERT,
    S_SHIFT_DN,
    S_GEN,
    S_GEN_END,
    S_READ
  } state_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_POS,
    IDX_INC,
    IDX_DEC,
    IDX_LAST
  } idx_op_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_UP,
    WR_DN,
    WR_NEW,
    WR_INC,
    WR_DEC
  } wr_op_e;

  typedef enum logic [1:0] {
    TOT_HOLD,
    TOT_INC,
    TOT_DEC,
    TOT_CLR
  } tot_op_e;

  typedef enum logic [1:0] {
    CAND_HOLD,
    CAND_ONE,
    CAND_RD_M1,
    CAND_PREV_P1
  } cand_op_e;

  typedef enum logic [1:0] {
    RID_ZERO,
    RID_RDATA,
    RID_CAND
  } rid_sel_e;

  typedef enum logic [2:0] {
    RCNT_ZERO,
    RCNT_ONE,
    RCNT_RDATA,
    RCNT_INC,
    RCNT_DEC
  } rcnt_sel_e;

  // Word index of the max_id register on the configuration port
  localparam logic REG_MAX_ID = 1'b0;

  typedef struct packed {
    logic      latch_in;
    idx_op_e   idx_op;
    logic      latch_p;
    logic      latch_prev;
    wr_op_e    wr_op;
    tot_op_e   tot_op;
    cand_op_e  cand_op;
    logic      res_load;
    status_e   res_status;
    rid_sel_e  rid_sel;
    rcnt_sel_e rcnt_sel;
  } ria_cmd_t;

  typedef struct packed {
    logic is_add;
    logic is_del;
    logic is_gen;
    logic is_clr;
    logic is_rd;
    logic id_bad;
    logic idx_lt_total;
    logic idx_next_lt_total;
    logic idx_zero;
    logic idx_eq_p;
    logic full;
    logic total_zero;
    logic rd_lt_id;
    logic rd_eq_id;
    logic rd_cnt_gt1;
    logic rd_gt1;
    logic gap;
    logic pos_lt_total;
    logic cand_gt_max;
  } ria_stat_t;

endpackage

`default_nettype wire

/* rtl/refcounted_id_allocator.sv */
// Top level: request port, result strobe, APB max_id register, controller and datapath.
//
// Usage: present func_i, id_value_i and position_i with start_i high; the
// request is taken at a clock edge where start_i is high and busy_o is low.
// busy_o stays high while the request walks the table. The result appears on
// status_o, result_id_o, result_count_o and used_entries_o for exactly one
// cycle, marked by done_o; the receiver cannot stall it. busy_o drops in that
// same cycle, so the next request may be taken while done_o is high.
// Clear and errors found at decode finish soonest, then read. Add, delete and
// generate walk the table, so they take longer the more IDs are stored: the
// table memory gives one entry read per cycle during the scan and one entry
// moved per cycle during a shift.
// Reset empties the table (the entry count clears; stored words are not
// cleared) and sets max_id to its largest value. max_id lives at byte address 0
// of the APB port; write it only while the block is idle.
`default_nettype none

module refcounted_id_allocator #(
  parameter int TABLE_DEPTH = 64,
  parameter int ID_BITS = 16,
  parameter int COUNT_BITS = 16,
  localparam int POS_W = $clog2(TABLE_DEPTH),
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [2:0]            func_i,
  input  wire logic [ID_BITS-1:0]    id_value_i,
  input  wire logic [POS_W-1:0]      position_i,
  output logic                       done_o,
  output logic [2:0]                 status_o,
  output logic [ID_BITS-1:0]         result_id_o,
  output logic [COUNT_BITS-1:0]      result_count_o,
  output logic [CNT_W-1:0]           used_entries_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  import ria_pkg::*;

  ria_cmd_t           cmd;
  ria_stat_t          stat;
  logic [ID_BITS-1:0] max_id_q;
  logic               cfg_wr;
  logic               sel_max_id;

  assign pready     = 1'b1;
  assign sel_max_id = (paddr[2] == REG_MAX_ID);
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign prdata     = sel_max_id ? 32'(max_id_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_id_q <= ID_BITS'(32'h0000_FFFF);
    end else if (cfg_wr && sel_max_id) begin
      max_id_q <= pwdata[ID_BITS-1:0];
    end
  end

  ria_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  ria_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .func_i         (func_i),
    .id_value_i     (id_value_i),
    .position_i     (position_i),
    .max_id_i       (max_id_q),
    .done_o         (done_o),
    .status_o       (status_o),
    .result_id_o    (result_id_o),
    .result_count_o (result_count_o),
    .used_entries_o (used_entries_o)
  );

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result strobe without a request in progress");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("accepted request did not occupy the block");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STAT_FULL)) |-> (used_entries_o == CNT_W'(TABLE_DEPTH)))
    else $error("table-full status while entries remain");

endmodule

`default_nettype wire

/* rtl/ria_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ria_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/ria_ctrl.sv */
// Controller state machine: sequences scan, shift and result steps per request.
`default_nettype none

module ria_ctrl (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  ria_pkg::ria_stat_t stat_i,
  output ria_pkg::ria_cmd_t  cmd_o,
  output logic           busy_o
);

  import ria_pkg::*;

  state_e state_q, state_d;
  logic   found;
  logic   scan_more;

  // Entry at the scan index matches the request ID
  assign found     = stat_i.idx_lt_total && stat_i.rd_eq_id;
  assign scan_more = stat_i.idx_lt_total && stat_i.rd_lt_id;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat_i.is_add) begin
          state_d = stat_i.id_bad ? S_IDLE : S_SCAN;
        end else if (stat_i.is_del) begin
          state_d = S_SCAN;
        end else if (stat_i.is_gen) begin
          state_d = stat_i.total_zero ? S_GEN_END : S_GEN;
        end else if (stat_i.is_rd) begin
          state_d = S_READ;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!scan_more) begin
          if (stat_i.is_add) begin
            if (found || stat_i.full) begin
              state_d = S_IDLE;
            end else if (stat_i.idx_lt_total) begin
              state_d = S_SHIFT_UP;
            end else begin
              state_d = S_INSERT;
            end
          end else if (found && !stat_i.rd_cnt_gt1 && stat_i.idx_next_lt_total) begin
            state_d = S_SHIFT_DN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SHIFT_UP: begin
        if (stat_i.idx_eq_p) state_d = S_INSERT;
      end
      S_INSERT: state_d = S_IDLE;
      S_SHIFT_DN: begin
        if (!stat_i.idx_next_lt_total) state_d = S_IDLE;
      end
      S_GEN: begin
        if (stat_i.idx_zero) begin
          if (stat_i.rd_gt1) state_d = S_GEN_END;
        end else if (!stat_i.idx_lt_total || stat_i.gap) begin
          state_d = S_GEN_END;
        end
      end
      S_GEN_END: state_d = S_IDLE;
      S_READ:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.idx_op     = IDX_HOLD;
    cmd_o.wr_op      = WR_NONE;
    cmd_o.tot_op     = TOT_HOLD;
    cmd_o.cand_op    = CAND_HOLD;
    cmd_o.res_status = STAT_OK;
    cmd_o.rid_sel    = RID_ZERO;
    cmd_o.rcnt_sel   = RCNT_ZERO;
    busy_o           = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        cmd_o.latch_in = start_i;
      end
      S_DISPATCH: begin
        if (stat_i.is_add) begin
          if (stat_i.id_bad) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = STAT_RANGE;
          end else begin
            cmd_o.idx_op = IDX_ZERO;
          end
        end else if (stat_i.is_del) begin
          cmd_o.idx_op = IDX_ZERO;
        end else if (stat_i.is_gen) begin
          if (stat_i.total_zero) begin
            cmd_o.cand_op = CAND_ONE;
          end else begin
            cmd_o.idx_op = IDX_ZERO;
          end
        end else if (stat_i.is_clr) begin
          cmd_o.tot_op   = TOT_CLR;
          cmd_o.res_load = 1'b1;
        end else if (stat_i.is_rd) begin
          cmd_o.idx_op = IDX_POS;
        end else begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = STAT_RANGE;
        end
      end
      S_SCAN: begin
        if (scan_more) begin
          cmd_o.idx_op = IDX_INC;
        end else if (stat_i.is_add) begin
          if (found) begin
            cmd_o.wr_op    = WR_INC;
            cmd_o.res_load = 1'b1;
            cmd_o.rcnt_sel = RCNT_INC;
          end else if (stat_i.full) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = STAT_FULL;
          end else begin
            cmd_o.latch_p = 1'b1;
            if (stat_i.idx_lt_total) cmd_o.idx_op = IDX_LAST;
          end
        end else if (!found) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = STAT_ABSENT;
        end else if (stat_i.rd_cnt_gt1) begin
          cmd_o.wr_op    = WR_DEC;
          cmd_o.res_load = 1'b1;
          cmd_o.rcnt_sel = RCNT_DEC;
        end else if (stat_i.idx_next_lt_total) begin
          cmd_o.idx_op = IDX_INC;
        end else begin
          cmd_o.tot_op   = TOT_DEC;
          cmd_o.res_load = 1'b1;
        end
      end
      S_SHIFT_UP: begin
        cmd_o.wr_op = WR_UP;
        if (!stat_i.idx_eq_p) cmd_o.idx_op = IDX_DEC;
      end
      S_INSERT: begin
        cmd_o.wr_op    = WR_NEW;
        cmd_o.tot_op   = TOT_INC;
        cmd_o.res_load = 1'b1;
        cmd_o.rcnt_sel = RCNT_ONE;
      end
      S_SHIFT_DN: begin
        cmd_o.wr_op = WR_DN;
        if (stat_i.idx_next_lt_total) begin
          cmd_o.idx_op = IDX_INC;
        end else begin
          cmd_o.tot_op   = TOT_DEC;
          cmd_o.res_load = 1'b1;
        end
      end
      S_GEN: begin
        if (stat_i.idx_zero) begin
          if (stat_i.rd_gt1) begin
            cmd_o.cand_op = CAND_RD_M1;
          end else begin
            cmd_o.latch_prev = 1'b1;
            cmd_o.idx_op     = IDX_INC;
          end
        end else if (stat_i.idx_lt_total && !stat_i.gap) begin
          cmd_o.latch_prev = 1'b1;
          cmd_o.idx_op     = IDX_INC;
        end else begin
          cmd_o.cand_op = CAND_PREV_P1;
        end
      end
      S_GEN_END: begin
        cmd_o.res_load = 1'b1;
        if (stat_i.cand_gt_max) begin
          cmd_o.res_status = STAT_NONE_FREE;
        end else begin
          cmd_o.rid_sel = RID_CAND;
        end
      end
      S_READ: begin
        cmd_o.res_load = 1'b1;
        if (stat_i.pos_lt_total) begin
          cmd_o.rid_sel  = RID_RDATA;
          cmd_o.rcnt_sel = RCNT_RDATA;
        end else begin
          cmd_o.res_status = STAT_BAD_POS;
        end
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/ria_dp.sv */
// Datapath: sorted ID/count table, scan index, total count and result registers.
`default_nettype none

module ria_dp #(
  parameter int TABLE_DEPTH = 64,
  parameter int ID_BITS = 16,
  parameter int COUNT_BITS = 16,
  localparam int POS_W = $clog2(TABLE_DEPTH),
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  ria_pkg::ria_cmd_t          cmd_i,
  output ria_pkg::ria_stat_t         stat_o,
  input  wire logic [2:0]            func_i,
  input  wire logic [ID_BITS-1:0]    id_value_i,
  input  wire logic [POS_W-1:0]      position_i,
  input  wire logic [ID_BITS-1:0]    max_id_i,
  output logic                       done_o,
  output logic [2:0]                 status_o,
  output logic [ID_BITS-1:0]         result_id_o,
  output logic [COUNT_BITS-1:0]      result_count_o,
  output logic [CNT_W-1:0]           used_entries_o
);

  import ria_pkg::*;

  localparam int WORD_W = ID_BITS + COUNT_BITS;

  logic [CNT_W-1:0]      idx_q, idx_d, p_q, total_q, total_d, waddr_full;
  logic [CNT_W:0]        idx_p1_wide;
  logic [2:0]            func_q;
  logic [ID_BITS-1:0]    id_q, prev_q;
  logic [POS_W-1:0]      pos_q;
  logic [ID_BITS:0]      cand_q, cand_d, prev_p1;
  logic                  we;
  logic [WORD_W-1:0]     wdata, rdata;
  logic [ID_BITS-1:0]    rd_id;
  logic [COUNT_BITS-1:0] rd_cnt, cnt_inc, cnt_dec;

  logic                  done_q;
  logic [2:0]            status_q;
  logic [ID_BITS-1:0]    rid_q, rid_d;
  logic [COUNT_BITS-1:0] rcnt_q, rcnt_d;
  logic [CNT_W-1:0]      used_q;

  assign rd_id   = rdata[WORD_W-1 -: ID_BITS];
  assign rd_cnt  = rdata[COUNT_BITS-1:0];
  assign cnt_inc = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
  assign cnt_dec = rd_cnt - COUNT_BITS'(1);
  assign prev_p1 = {1'b0, prev_q} + (ID_BITS + 1)'(1);
  assign idx_p1_wide = {1'b0, idx_q} + (CNT_W + 1)'(1);

  // Read address follows the next index, so read data always matches idx_q
  always_comb begin
    case (cmd_i.idx_op)
      IDX_ZERO: idx_d = '0;
      IDX_POS:  idx_d = CNT_W'(pos_q);
      IDX_INC:  idx_d = idx_q + CNT_W'(1);
      IDX_DEC:  idx_d = idx_q - CNT_W'(1);
      IDX_LAST: idx_d = total_q - CNT_W'(1);
      default:  idx_d = idx_q;
    endcase
  end

  always_comb begin
    case (cmd_i.tot_op)
      TOT_INC: total_d = total_q + CNT_W'(1);
      TOT_DEC: total_d = total_q - CNT_W'(1);
      TOT_CLR: total_d = '0;
      default: total_d = total_q;
    endcase
  end

  always_comb begin
    we         = 1'b1;
    waddr_full = idx_q;
    wdata      = rdata;
    case (cmd_i.wr_op)
      WR_UP:   waddr_full = idx_q + CNT_W'(1);
      WR_DN:   waddr_full = idx_q - CNT_W'(1);
      WR_NEW: begin
        waddr_full = p_q;
        wdata      = {id_q, COUNT_BITS'(1)};
      end
      WR_INC:  wdata = {rd_id, cnt_inc};
      WR_DEC:  wdata = {rd_id, cnt_dec};
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd_i.cand_op)
      CAND_ONE:     cand_d = (ID_BITS + 1)'(1);
      CAND_RD_M1:   cand_d = {1'b0, rd_id - ID_BITS'(1)};
      CAND_PREV_P1: cand_d = prev_p1;
      default:      cand_d = cand_q;
    endcase
  end

  always_comb begin
    case (cmd_i.rid_sel)
      RID_RDATA: rid_d = rd_id;
      RID_CAND:  rid_d = cand_q[ID_BITS-1:0];
      default:   rid_d = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.rcnt_sel)
      RCNT_ONE:   rcnt_d = COUNT_BITS'(1);
      RCNT_RDATA: rcnt_d = rd_cnt;
      RCNT_INC:   rcnt_d = cnt_inc;
      RCNT_DEC:   rcnt_d = cnt_dec;
      default:    rcnt_d = '0;
    endcase
  end

  ria_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr_full[POS_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_d[POS_W-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      p_q     <= '0;
      total_q <= '0;
      done_q  <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      total_q <= total_d;
      done_q  <= cmd_i.res_load;
      if (cmd_i.latch_p) p_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      func_q <= func_i;
      id_q   <= id_value_i;
      pos_q  <= position_i;
    end
    if (cmd_i.latch_prev) prev_q <= rd_id;
    cand_q <= cand_d;
    if (cmd_i.res_load) begin
      status_q <= cmd_i.res_status;
      rid_q    <= rid_d;
      rcnt_q   <= rcnt_d;
      used_q   <= total_d;
    end
  end

  always_comb begin
    stat_o.is_add            = (func_q == FUNC_ADD);
    stat_o.is_del            = (func_q == FUNC_DEL);
    stat_o.is_gen            = (func_q == FUNC_GEN);
    stat_o.is_clr            = (func_q == FUNC_CLR);
    stat_o.is_rd             = (func_q == FUNC_READ);
    stat_o.id_bad            = (id_q == '0) || (id_q > max_id_i);
    stat_o.idx_lt_total      = (idx_q < total_q);
    stat_o.idx_next_lt_total = (idx_p1_wide < {1'b0, total_q});
    stat_o.idx_zero          = (idx_q == '0);
    stat_o.idx_eq_p          = (idx_q == p_q);
    stat_o.full              = (total_q == CNT_W'(TABLE_DEPTH));
    stat_o.total_zero        = (total_q == '0);
    stat_o.rd_lt_id          = (rd_id < id_q);
    stat_o.rd_eq_id          = (rd_id == id_q);
    stat_o.rd_cnt_gt1        = (rd_cnt > COUNT_BITS'(1));
    stat_o.rd_gt1            = (rd_id > ID_BITS'(1));
    stat_o.gap               = ({1'b0, rd_id} > prev_p1);
    stat_o.pos_lt_total      = (CNT_W'(pos_q) < total_q);
    stat_o.cand_gt_max       = (cand_q > {1'b0, max_id_i});
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign result_id_o    = rid_q;
  assign result_count_o = rcnt_q;
  assign used_entries_o = used_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry total exceeds table depth");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> waddr_full <= total_q)
    else $error("table write beyond the filled region");

  a_no_grow_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.tot_op == TOT_INC) |-> (total_q < CNT_W'(TABLE_DEPTH)))
    else $error("insert into a full table");

endmodule

`default_nettype wire

/* sim/tb_refcounted_id_allocator.sv */
// Self-checking testbench for the reference-counted ID allocator.
module tb_refcounted_id_allocator;
  import ria_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [15:0] COUNT_TOP = 16'hFFFF;
  localparam logic [15:0] ID_TOP = 16'hFFFF;
  localparam logic [2:0] FUNC_BAD_LO = 3'd5;
  localparam logic [2:0] FUNC_BAD_HI = 3'd7;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    status_e     status;
    logic [15:0] rid;
    logic [15:0] rcnt;
    logic [6:0]  used;
  } alloc_reply_t;

  class alloc_scoreboard;
    logic [15:0]  ids[DEPTH];
    logic [15:0]  counts[DEPTH];
    int           total;
    logic [15:0]  max_id;
    int           errors;
    alloc_reply_t replies_due[$];

    function new();
      total = 0;
      max_id = ID_TOP;
      errors = 0;
    endfunction

    // Compute the reply for one accepted request and update the shadow table.
    function void predict_reply(logic [2:0] f, logic [15:0] id, logic [5:0] pos);
      alloc_reply_t r;
      int p;
      int i;
      int cand;
      r.status = STAT_OK;
      r.rid = '0;
      r.rcnt = '0;
      p = 0;
      case (f)
        FUNC_ADD: begin
          if (id == 0 || id > max_id) begin
            r.status = STAT_RANGE;
          end else begin
            while (p < total && ids[p] < id) p++;
            if (p < total && ids[p] == id) begin
              if (counts[p] < COUNT_TOP) counts[p]++;
              r.rcnt = counts[p];
            end else if (total >= DEPTH) begin
              r.status = STAT_FULL;
            end else begin
              for (i = total; i > p; i--) begin
                ids[i] = ids[i-1];
                counts[i] = counts[i-1];
              end
              ids[p] = id;
              counts[p] = 16'd1;
              total++;
              r.rcnt = 16'd1;
            end
          end
        end
        FUNC_DEL: begin
          while (p < total && ids[p] < id) p++;
          if (!(p < total && ids[p] == id)) begin
            r.status = STAT_ABSENT;
          end else if (counts[p] > 1) begin
            counts[p]--;
            r.rcnt = counts[p];
          end else begin
            for (i = p; i + 1 < total; i++) begin
              ids[i] = ids[i+1];
              counts[i] = counts[i+1];
            end
            total--;
          end
        end
        FUNC_GEN: begin
          if (total == 0) begin
            cand = 1;
          end else if (ids[0] > 1) begin
            cand = int'(ids[0]) - 1;
          end else begin
            cand = int'(ids[total-1]) + 1;
            for (i = 0; i + 1 < total; i++) begin
              if (int'(ids[i+1]) - int'(ids[i]) > 1) begin
                cand = int'(ids[i]) + 1;
                break;
              end
            end
          end
          if (cand > int'(max_id)) r.status = STAT_NONE_FREE;
          else r.rid = cand[15:0];
        end
        FUNC_CLR: total = 0;
        FUNC_READ: begin
          if (int'(pos) < total) begin
            r.rid = ids[pos];
            r.rcnt = counts[pos];
          end else begin
            r.status = STAT_BAD_POS;
          end
        end
        default: r.status = STAT_RANGE;
      endcase
      r.used = total[6:0];
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [2:0] st, logic [15:0] rid, logic [15:0] rcnt,
                              logic [6:0] used);
      alloc_reply_t e;
      if (replies_due.size() == 0) begin
        $error("unexpected result: status %0d id %0d count %0d", st, rid, rcnt);
        errors++;
        return;
      end
      e = replies_due.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (rid !== e.rid) begin
        $error("result_id: expected %0d, got %0d", e.rid, rid);
        errors++;
      end
      if (rcnt !== e.rcnt) begin
        $error("result_count: expected %0d, got %0d", e.rcnt, rcnt);
        errors++;
      end
      if (used !== e.used) begin
        $error("used_entries: expected %0d, got %0d", e.used, used);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [2:0]  func_i = '0;
  logic [15:0] id_value_i = '0;
  logic [5:0]  position_i = '0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic        busy_o;
  logic        done_o;
  logic [2:0]  status_o;
  logic [15:0] result_id_o;
  logic [15:0] result_count_o;
  logic [6:0]  used_entries_o;
  logic [31:0] prdata;
  logic        pready;

  alloc_scoreboard sb;
  int stall_cycles = 0;

  refcounted_id_allocator uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .func_i         (func_i),
    .id_value_i     (id_value_i),
    .position_i     (position_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .result_id_o    (result_id_o),
    .result_count_o (result_count_o),
    .used_entries_o (used_entries_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1)
      sb.check_reply(status_o, result_id_o, result_count_o, used_entries_o);
  end

  // Drop the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || psel) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[refcounted_id_allocator] ERROR");
        $finish;
      end
    end
  end

  // Hold the request until the block takes it; start stays high afterwards.
  task automatic send_request(input logic [2:0] f, input logic [15:0] id,
                              input logic [5:0] pos);
    start_i <= 1'b1;
    func_i <= f;
    id_value_i <= id;
    position_i <= pos;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.predict_reply(f, id, pos);
  endtask

  task automatic pause(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (sb.replies_due.size() != 0 || busy_o) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write max_id, then read it back.
  task automatic write_max_id(input logic [15:0] val);
    logic [15:0] junk;
    junk = $urandom;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_MAX_ID, 2'b00};
    pwdata <= {junk, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.max_id = val;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== val) begin
      $error("max_id: expected %0d, got %0d", val, prdata[15:0]);
      sb.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [15:0] pick_id(int lo, int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) begin
      if (sb.max_id < ID_TOP) return 16'($urandom_range(int'(sb.max_id) + 1, 65535));
      return ID_TOP;
    end
    if (r < 12) return 16'($urandom);
    return 16'($urandom_range(lo, hi));
  endfunction

  task automatic run_phase(input logic [15:0] new_max, input int lo, input int hi,
                           input int n);
    int sent;
    int burst;
    int mode;
    int roll;
    int k;
    logic [2:0] f;
    logic [15:0] id;
    logic [5:0] pos;
    wait_idle();
    write_max_id(new_max);
    sent = 0;
    while (sent < n) begin
      roll = $urandom_range(0, 99);
      mode = (roll < 45) ? 0 : (roll < 80) ? 2 : 1;
      burst = ($urandom_range(0, 99) < 15) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (k = 0; k < burst; k++) begin
        roll = $urandom_range(0, 199);
        if (mode == 0) begin
          f = (roll < 110) ? FUNC_ADD : (roll < 135) ? FUNC_DEL : (roll < 160) ? FUNC_GEN :
              (roll < 190) ? FUNC_READ : 3'($urandom_range(FUNC_BAD_LO, FUNC_BAD_HI));
        end else if (mode == 1) begin
          f = (roll < 40) ? FUNC_ADD : (roll < 130) ? FUNC_DEL : (roll < 155) ? FUNC_GEN :
              (roll < 185) ? FUNC_READ : (roll < 187) ? FUNC_CLR :
              3'($urandom_range(FUNC_BAD_LO, FUNC_BAD_HI));
        end else begin
          f = (roll < 75) ? FUNC_ADD : (roll < 120) ? FUNC_DEL : (roll < 150) ? FUNC_GEN :
              (roll < 185) ? FUNC_READ : (roll < 186) ? FUNC_CLR :
              3'($urandom_range(FUNC_BAD_LO, FUNC_BAD_HI));
        end
        pos = $urandom;
        id = $urandom;
        if (f == FUNC_ADD) begin
          id = pick_id(lo, hi);
        end else if (f == FUNC_DEL) begin
          if (sb.total > 0 && $urandom_range(0, 99) < 70)
            id = sb.ids[$urandom_range(0, sb.total - 1)];
          else
            id = pick_id(lo, hi);
        end else if (f == FUNC_READ && $urandom_range(0, 99) < 80) begin
          pos = 6'($urandom_range(0, (sb.total < DEPTH) ? sb.total : DEPTH - 1));
        end
        send_request(f, id, pos);
        sent++;
      end
      roll = $urandom_range(0, 99);
      if (roll >= 80) pause($urandom_range(13, 150));
      else if (roll >= 30) pause($urandom_range(1, 12));
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_max_id(ID_TOP);

    // Empty table, range errors, gaps, removal and unknown operations.
    send_request(FUNC_GEN, 16'd0, 6'd0);
    send_request(FUNC_READ, 16'd0, 6'd0);
    send_request(FUNC_DEL, 16'd5, 6'd0);
    send_request(FUNC_ADD, 16'd0, 6'd0);
    send_request(FUNC_ADD, ID_TOP, 6'd63);
    send_request(FUNC_ADD, 16'd1, 6'd0);
    send_request(FUNC_ADD, 16'd1, 6'd0);
    send_request(FUNC_GEN, 16'd0, 6'd0);
    send_request(FUNC_ADD, 16'd3, 6'd0);
    send_request(FUNC_GEN, 16'd0, 6'd0);
    send_request(FUNC_ADD, 16'd2, 6'd0);
    send_request(FUNC_GEN, 16'd0, 6'd0);
    send_request(FUNC_DEL, 16'd1, 6'd0);
    send_request(FUNC_DEL, 16'd1, 6'd0);
    send_request(FUNC_GEN, 16'd0, 6'd0);
    send_request(FUNC_READ, 16'd0, 6'd63);
    send_request(FUNC_READ, 16'd0, 6'd2);
    send_request(FUNC_BAD_LO, 16'd7, 6'd1);
    send_request(3'd6, 16'd7, 6'd1);
    send_request(FUNC_BAD_HI, ID_TOP, 6'd63);
    send_request(FUNC_DEL, 16'd0, 6'd0);
    send_request(FUNC_CLR, ID_TOP, 6'd63);
    send_request(FUNC_GEN, 16'd0, 6'd0);

    // Smallest max_id: only ID 1 fits.
    wait_idle();
    write_max_id(16'd1);
    send_request(FUNC_ADD, 16'd1, 6'd0);
    send_request(FUNC_GEN, 16'd0, 6'd0);
    send_request(FUNC_ADD, 16'd2, 6'd0);
    send_request(FUNC_DEL, 16'd1, 6'd0);
    send_request(FUNC_GEN, 16'd0, 6'd0);

    // Fill from the top down so every insert shifts the whole table.
    wait_idle();
    write_max_id(16'd64);
    for (int k = DEPTH; k >= 1; k--) send_request(FUNC_ADD, 16'(k), 6'd0);
    send_request(FUNC_GEN, 16'd0, 6'd0);
    send_request(FUNC_ADD, 16'd65, 6'd0);
    wait_idle();
    write_max_id(ID_TOP);
    send_request(FUNC_ADD, 16'd100, 6'd0);
    send_request(FUNC_ADD, 16'd7, 6'd0);
    send_request(FUNC_READ, 16'd0, 6'd63);
    // Lower max_id below most of the stored entries.
    wait_idle();
    write_max_id(16'd10);
    send_request(FUNC_GEN, 16'd0, 6'd0);
    send_request(FUNC_DEL, 16'd1, 6'd0);
    send_request(FUNC_GEN, 16'd0, 6'd0);
    send_request(FUNC_DEL, 16'd64, 6'd0);
    send_request(FUNC_DEL, 16'd7, 6'd0);
    send_request(FUNC_DEL, 16'd7, 6'd0);
    send_request(FUNC_ADD, 16'd1, 6'd0);
    send_request(FUNC_GEN, 16'd0, 6'd0);

    run_phase(ID_TOP, 1, 90, 400);
    run_phase(16'd64, 1, 64, 350);
    run_phase(16'd20, 1, 40, 200);
    run_phase(16'd1, 1, 2, 150);
    run_phase(ID_TOP, 65400, 65535, 300);
    run_phase(16'd30000, 0, 65535, 300);
    run_phase(16'd200, 1, 200, 300);

    // Raise one count well above one, then step it down once.
    wait_idle();
    write_max_id(ID_TOP);
    send_request(FUNC_CLR, 16'd0, 6'd0);
    for (int k = 0; k < 100; k++) send_request(FUNC_ADD, ID_TOP, 6'($urandom));
    send_request(FUNC_READ, 16'd0, 6'd0);
    send_request(FUNC_DEL, ID_TOP, 6'd0);
    send_request(FUNC_READ, 16'd0, 6'd0);
    send_request(FUNC_CLR, 16'd0, 6'd0);

    start_i <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk_i);
    repeat (2 * DEPTH + 8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[refcounted_id_allocator] OK");
    end else begin
      $display("[refcounted_id_allocator] ERROR");
    end
    $finish;
  end

endmodule
